// ===== rtl/keyed_queue_priority_sort_top_defines.svh =====
// assertion helpers for the keyed queue
`ifndef KEYED_QUEUE_PRIORITY_SORT_TOP_DEFINES_SVH
`define KEYED_QUEUE_PRIORITY_SORT_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define KQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define KQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kqps_pkg.sv =====
package kqps_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned IDENT_W   = 37;
  localparam int unsigned PRIO_W    = 2;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned STAT_W    = 3;
  localparam int unsigned POS_W     = 5;

  localparam logic [CMD_W-1:0] CMD_ENQ    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SORT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_LIST   = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_FEW      = 3'd4;

  localparam logic [PRIO_W-1:0] PRIO_LOW  = 2'd1;
  localparam logic [PRIO_W-1:0] PRIO_HIGH = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [IDENT_W-1:0] ident;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

endpackage

// ===== rtl/keyed_queue_priority_sort_top.sv =====
// keyed priority queue, command interface
// a command transfer happens when start is high and busy is low; in_command selects
// enqueue, dequeue, remove by key, sort, find or list, with in_key, in_ident and
// in_prio_in as operands. results appear for one cycle with out_valid high and
// must be taken then; the receiver has no way to stall, so none is needed.
// the entries live in one synchronous memory (one read, one write port, read data
// registered), walked slot by slot by a small sequencer.
// what each command does, n entries held:
//   enqueue, and full, empty or sort of fewer than two: answered from idle; unknown codes give none
//   dequeue: the head is read and the rest move up one slot a cycle
//   remove: scans for the first key match, then the rest move up; no match: not found
//   find: scans for the first key match and returns it; no match: not found
//   list: entries are shown in order, one a cycle, out_last on the final one
//   sort: stable insertion sort with single reads and writes; it is the slowest command by far
// busy stays high from the transfer until the final result has been shown, so one
// command is in flight at a time; the next transfer can come once busy falls after
// the final result.
// after reset the queue is empty; the memory holds no defined contents and is only
// read below the count, so no clearing pass is done.
`include "keyed_queue_priority_sort_top_defines.svh"
module keyed_queue_priority_sort_top #(
  parameter int unsigned DEPTH = kqps_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [kqps_pkg::CMD_W-1:0]     in_command,
  input  logic [kqps_pkg::KEY_W-1:0]     in_key,
  input  logic [kqps_pkg::IDENT_W-1:0]   in_ident,
  input  logic [2:0]                     in_prio_in,
  output logic                           out_valid,
  output logic [kqps_pkg::STAT_W-1:0]    out_status,
  output logic [kqps_pkg::KEY_W-1:0]     out_key_out,
  output logic [kqps_pkg::IDENT_W-1:0]   out_ident_out,
  output logic [kqps_pkg::PRIO_W-1:0]    out_prio_out,
  output logic [kqps_pkg::POS_W-1:0]     out_position,
  output logic [kqps_pkg::POS_W-1:0]     out_occupancy,
  output logic                           out_last
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // one-hot sequencer states
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SCAN  = 10'b0000000010,  // compare key of slot idx, read slot idx+1
    S_SHIFT = 10'b0000000100,  // compaction: write slot idx+1 into idx, read idx+2
    S_LIST  = 10'b0000001000,
    S_SOUT  = 10'b0000010000,  // sort: fetch element i
    S_SHOLD = 10'b0000100000,  // sort: element i read data arrives
    S_SCMP  = 10'b0001000000,  // sort: compare slot j-1
    S_SPUT  = 10'b0010000000,  // sort: place held element
    S_RESP  = 10'b0100000000,
    S_WAIT  = 10'b1000000000   // read latency bubble before scan compare
  } state_t;

  state_t state_r, state_nxt;

  kqps_pkg::entry_t mem [DEPTH];
  kqps_pkg::entry_t rd_q;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  kqps_pkg::entry_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  logic [CW-1:0]                 count_r, count_nxt;
  logic [kqps_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [kqps_pkg::KEY_W-1:0]    key_r, key_nxt;
  logic [CW-1:0]                 idx_r, idx_nxt;    // scan / list / sort outer index
  logic [CW-1:0]                 j_r, j_nxt;        // sort inner index
  logic                          rv_r, rv_nxt;      // read data of slot idx_r+1 pending
  kqps_pkg::entry_t              hold_r, hold_nxt;  // removed or sorted element
  logic [CW-1:0]                 hpos_r, hpos_nxt;

  // registered result
  logic                          ov_r, ov_nxt;
  logic [kqps_pkg::STAT_W-1:0]   ost_r, ost_nxt;
  kqps_pkg::entry_t              oe_r, oe_nxt;
  logic [kqps_pkg::POS_W-1:0]    opos_r, opos_nxt;
  logic                          olast_r, olast_nxt;

  logic                          accept;
  logic [kqps_pkg::PRIO_W-1:0]   prio_fix;
  logic [CW-1:0]                 idx_inc;

  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign prio_fix = (in_prio_in >= 3'd1 && in_prio_in <= 3'd3) ?
                    in_prio_in[kqps_pkg::PRIO_W-1:0] : kqps_pkg::PRIO_LOW;
  assign idx_inc  = idx_r + CW'(1);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    cmd_nxt   = cmd_r;
    key_nxt   = key_r;
    idx_nxt   = idx_r;
    j_nxt     = j_r;
    rv_nxt    = 1'b0;
    hold_nxt  = hold_r;
    hpos_nxt  = hpos_r;
    ov_nxt    = 1'b0;
    ost_nxt   = kqps_pkg::ST_OK;
    oe_nxt    = '0;
    opos_nxt  = '0;
    olast_nxt = 1'b1;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt = in_command;
          key_nxt = in_key;
          idx_nxt = '0;
          case (in_command)
            kqps_pkg::CMD_ENQ: begin
              state_nxt = S_RESP;
              ov_nxt    = 1'b1;
              if (count_r >= CW'(DEPTH)) begin
                ost_nxt = kqps_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = count_r[AW-1:0];
                wr_data   = '{key: in_key, ident: in_ident, prio: prio_fix};
                count_nxt = count_r + CW'(1);
                oe_nxt    = wr_data;
                opos_nxt  = kqps_pkg::POS_W'(count_nxt);
              end
            end
            kqps_pkg::CMD_DEQ, kqps_pkg::CMD_REMOVE, kqps_pkg::CMD_FIND,
            kqps_pkg::CMD_LIST: begin
              if (count_r == '0) begin
                state_nxt = S_RESP;
                ov_nxt    = 1'b1;
                ost_nxt   = kqps_pkg::ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = (in_command == kqps_pkg::CMD_LIST) ? S_LIST : S_WAIT;
              end
            end
            kqps_pkg::CMD_SORT: begin
              if (count_r <= CW'(1)) begin
                state_nxt = S_RESP;
                ov_nxt    = 1'b1;
                ost_nxt   = kqps_pkg::ST_FEW;
              end else begin
                idx_nxt   = CW'(1);
                state_nxt = S_SOUT;
              end
            end
            default: state_nxt = S_RESP;  // unknown code, no result
          endcase
        end
      end

      S_WAIT: state_nxt = S_SCAN;  // rd_q now holds slot idx

      S_SCAN: begin
        // rd_q holds slot idx_r
        if (cmd_r == kqps_pkg::CMD_DEQ || rd_q.key == key_r) begin
          hold_nxt = rd_q;
          hpos_nxt = idx_inc;
          if (cmd_r == kqps_pkg::CMD_FIND) begin
            state_nxt = S_RESP;
            ov_nxt    = 1'b1;
            oe_nxt    = rd_q;
            opos_nxt  = kqps_pkg::POS_W'(idx_inc);
          end else begin
            // start compaction at idx_r
            state_nxt = S_SHIFT;
            if (idx_inc < count_r) begin
              rd_en   = 1'b1;
              rd_addr = idx_inc[AW-1:0];
              rv_nxt  = 1'b1;
            end
          end
        end else if (idx_inc < count_r) begin
          idx_nxt   = idx_inc;
          rd_en     = 1'b1;
          rd_addr   = idx_inc[AW-1:0];
          state_nxt = S_WAIT;
        end else begin
          state_nxt = S_RESP;
          ov_nxt    = 1'b1;
          ost_nxt   = kqps_pkg::ST_NOTFOUND;
        end
      end

      S_SHIFT: begin
        if (rv_r) begin
          // rd_q holds slot idx+1, move it down
          wr_en   = 1'b1;
          wr_addr = idx_r[AW-1:0];
          wr_data = rd_q;
          idx_nxt = idx_inc;
          if (idx_inc + CW'(1) < count_r) begin
            rd_en   = 1'b1;
            rd_addr = idx_nxt[AW-1:0] + AW'(1);
            rv_nxt  = 1'b1;
          end
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_RESP;
          ov_nxt    = 1'b1;
          oe_nxt    = hold_r;
          opos_nxt  = kqps_pkg::POS_W'(hpos_r);
        end
      end

      S_LIST: begin
        // rd_q holds slot idx_r
        ov_nxt    = 1'b1;
        oe_nxt    = rd_q;
        opos_nxt  = kqps_pkg::POS_W'(idx_inc);
        olast_nxt = (idx_inc == count_r);
        idx_nxt   = idx_inc;
        if (idx_inc < count_r) begin
          rd_en   = 1'b1;
          rd_addr = idx_inc[AW-1:0];
        end else begin
          state_nxt = S_RESP;
        end
      end

      S_SOUT: begin
        if (idx_r < count_r) begin
          rd_en     = 1'b1;
          rd_addr   = idx_r[AW-1:0];
          j_nxt     = idx_r;
          state_nxt = S_SHOLD;
        end else begin
          state_nxt = S_RESP;
          ov_nxt    = 1'b1;
        end
      end

      S_SHOLD: begin
        hold_nxt  = rd_q;
        rd_en     = 1'b1;
        rd_addr   = j_r[AW-1:0] - AW'(1);
        state_nxt = S_SCMP;
      end

      S_SCMP: begin
        // rd_q holds slot j-1
        if (rd_q.prio < hold_r.prio) begin
          wr_en   = 1'b1;
          wr_addr = j_r[AW-1:0];
          wr_data = rd_q;
          j_nxt   = j_r - CW'(1);
          if (j_r > CW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = j_r[AW-1:0] - AW'(2);
          end else begin
            state_nxt = S_SPUT;
          end
        end else begin
          state_nxt = S_SPUT;
        end
      end

      S_SPUT: begin
        wr_en     = 1'b1;
        wr_addr   = j_r[AW-1:0];
        wr_data   = hold_r;
        idx_nxt   = idx_inc;
        state_nxt = S_SOUT;
      end

      S_RESP: state_nxt = S_IDLE;  // result register drains

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      rv_r    <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    key_r   <= key_nxt;
    idx_r   <= idx_nxt;
    j_r     <= j_nxt;
    hold_r  <= hold_nxt;
    hpos_r  <= hpos_nxt;
    ost_r   <= ost_nxt;
    oe_r    <= oe_nxt;
    opos_r  <= opos_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid     = ov_r;
  assign out_status    = ost_r;
  assign out_key_out   = oe_r.key;
  assign out_ident_out = oe_r.ident;
  assign out_prio_out  = oe_r.prio;
  assign out_position  = opos_r;
  assign out_occupancy = kqps_pkg::POS_W'(count_r);
  assign out_last      = olast_r;

  // checks
  `KQ_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "count above depth")
  `KQ_ASSERT_IMP(a_write_in_range, wr_en, wr_addr < count_r || state_r == S_IDLE,
                 "write beyond the count")
  `KQ_ASSERT_NXT(a_busy_after_accept, accept, busy, "busy low after a transfer")
  `KQ_ASSERT_IMP(a_result_busy, out_valid && !out_last, busy,
                 "list ended early")

endmodule
